>>> rtl/joystick_stepper_half_step_drive_defines.svh
// ----------------------------------------------------------------------------
// joystick stepper half-step drive - assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_STEPPER_HALF_STEP_DRIVE_DEFINES_SVH
`define JOYSTICK_STEPPER_HALF_STEP_DRIVE_DEFINES_SVH

// same-cycle implication
`define JSHS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jshs assertion failed");

// next-cycle implication
`define JSHS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jshs assertion failed");

`endif

>>> rtl/jshs_pkg.sv
// ----------------------------------------------------------------------------
// jshs_pkg
// types, register indexes, reset values and the coil table of the drive
// ----------------------------------------------------------------------------
`default_nettype none

package jshs_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_IV,
		ST_DONE
	} jshs_state_t;

	localparam logic [1:0] REG_DEADBAND = 2'd0;
	localparam logic [1:0] REG_SLOWEST  = 2'd1;
	localparam logic [1:0] REG_FASTEST  = 2'd2;

	localparam logic [8:0] DEADBAND_RST = 9'd50;
	localparam logic [9:0] SLOWEST_RST  = 10'd30;
	localparam logic [9:0] FASTEST_RST  = 10'd2;

	// half-step sequence, bit0 is the first coil
	function automatic logic [3:0] coil_lookup(input logic [2:0] phase);
		logic [3:0] pat;
		case (phase)
			3'd0: pat = 4'b0001;
			3'd1: pat = 4'b0011;
			3'd2: pat = 4'b0010;
			3'd3: pat = 4'b0110;
			3'd4: pat = 4'b0100;
			3'd5: pat = 4'b1100;
			3'd6: pat = 4'b1000;
			3'd7: pat = 4'b1001;
			default: pat = 4'b0000;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

>>> rtl/joystick_stepper_half_step_drive.sv
// ----------------------------------------------------------------------------
// joystick_stepper_half_step_drive
// joystick axis sample in, half-step coil pattern out, one result per tick
// ----------------------------------------------------------------------------
// usage:
//   s_* channel: one transfer per tick, carrying one joystick axis sample
//   m_* channel: one transfer per tick: coil pattern, motion flag, running
//   cfg_* channel: register writes (deadband, slowest, fastest interval),
//   always ready, to be used only while no tick is in flight
// timing:
//   a sample inside the deadband goes from its transfer straight to the
//   result state; one outside first passes the multiply, divide and interval
//   states, the restoring divider retiring one quotient bit a cycle
//   over the SAMPLE_BITS + 10 bit product of the offset and interval span
//   s_tready is high only while the sequencer is idle, so one tick is in
//   work at a time; the next tick may be taken while a result still waits
// reset:
//   arst_n clears coils, flag, tick counter and phase, and loads the
//   register defaults (deadband 50, slowest 30, fastest 2)
// stall:
//   a result that is not taken holds m_tdata; the sequencer parks in its
//   final state until m_tready frees the output slot
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_stepper_half_step_drive
	import jshs_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// input stream
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // joystick_sample
	// output stream
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	output logic [7:0]                                  m_tdata,  // coil_pattern[3:0],
	                                                                // motion_flag, running
	// register writes
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [1:0]                             cfg_index,
	input  wire logic [9:0]                             cfg_data
);

`include "joystick_stepper_half_step_drive_defines.svh"

	// widths
	localparam int SB   = SAMPLE_BITS;
	localparam int CW   = (SB > 9) ? SB : 9;       // compare width, sample vs deadband
	localparam int PW   = SB + 10;                 // product and quotient width
	localparam int CNTW = $clog2(PW);
	localparam logic [SB-1:0]   MID      = {1'b1, {(SB - 1){1'b0}}};
	localparam logic [CNTW-1:0] DIV_LAST = CNTW'(PW - 1);

	// configuration registers
	logic [8:0] deadband_q;
	logic [9:0] slowest_q;
	logic [9:0] fastest_q;

	// drive state, also the output register
	logic       run_mode_q;
	logic [2:0] phase_q;
	logic [9:0] tick_q;
	logic [3:0] coil_q;
	logic       motion_q;
	logic       m_tvalid_q;

	// sequencer
	jshs_state_t state_q, state_d;
	logic [CNTW-1:0] cnt_q;

	// per-tick working registers
	logic          neg_q;
	logic          run_q;
	logic [SB-1:0] mag_q;
	logic [9:0]    span_q;
	logic [SB-1:0] den_q;
	logic [SB-1:0] rem_q;
	logic [PW-1:0] prod_q;   // product, shifted out while the quotient shifts in
	logic [9:0]    iv_q;

	// decoded sequencer outputs
	logic in_take;
	logic do_mul;
	logic do_div;
	logic do_iv;
	logic out_free;
	logic do_done;

	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------- datapath
	logic [SB-1:0] sample;
	logic          neg;
	logic [SB-1:0] mag;
	logic          run;
	logic [9:0]    span;

	assign sample = s_tdata[SB-1:0];
	assign neg    = sample < MID;
	assign mag    = neg ? (MID - sample) : (sample - MID);
	assign run    = CW'(mag) > CW'(deadband_q);
	assign span   = (slowest_q > fastest_q) ? (slowest_q - fastest_q) : 10'd0;

	// offset beyond the deadband and distance from deadband edge to mid-scale
	logic [CW-1:0] diff_w;
	logic [CW-1:0] den_w;
	assign diff_w = CW'(mag_q) - CW'(deadband_q);
	assign den_w  = CW'(MID) - CW'(deadband_q);

	// one restoring divide step
	logic [SB:0]   trial;
	logic          q_bit;
	logic [SB:0]   trial_sub;
	assign trial     = {rem_q, prod_q[PW-1]};
	assign q_bit     = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	// interval from the quotient: linear fall, clamped at the fastest
	logic [9:0] iv_raw;
	logic [9:0] iv;
	assign iv_raw = (prod_q <= PW'(slowest_q)) ? (slowest_q - prod_q[9:0]) : 10'd0;
	assign iv     = (iv_raw < fastest_q) ? fastest_q : iv_raw;

	// step decision
	logic [9:0] tick_inc;
	logic       step;
	logic [2:0] phase_step;
	assign tick_inc   = tick_q + 10'd1;
	assign step       = tick_inc >= iv_q;
	assign phase_step = neg_q ? (phase_q + 3'd1) : (phase_q - 3'd1);

	always_ff @(posedge clk) begin
		if (in_take) begin
			neg_q  <= neg;
			run_q  <= run;
			mag_q  <= mag;
			span_q <= span;
		end
		if (do_mul) begin
			prod_q <= PW'(diff_w[SB-1:0]) * PW'(span_q);
			den_q  <= den_w[SB-1:0];
			rem_q  <= '0;
		end
		if (do_div) begin
			rem_q  <= q_bit ? trial_sub[SB-1:0] : trial[SB-1:0];
			prod_q <= {prod_q[PW-2:0], q_bit};
		end
		if (do_iv) begin
			iv_q <= iv;
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) begin
				state_d = run ? ST_MUL : ST_DONE;
			end
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (cnt_q == DIV_LAST) begin
				state_d = ST_IV;
			end
			ST_IV:   state_d = ST_DONE;
			ST_DONE: if (out_free) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		s_tready = 1'b0;
		do_mul   = 1'b0;
		do_div   = 1'b0;
		do_iv    = 1'b0;
		do_done  = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL:  do_mul   = 1'b1;
			ST_DIV:  do_div   = 1'b1;
			ST_IV:   do_iv    = 1'b1;
			ST_DONE: do_done  = out_free;
			default: s_tready = 1'b0;
		endcase
	end

	assign in_take = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (do_div) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RST;
			slowest_q  <= SLOWEST_RST;
			fastest_q  <= FASTEST_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEADBAND: deadband_q <= cfg_data[8:0];
				REG_SLOWEST:  slowest_q  <= cfg_data;
				REG_FASTEST:  fastest_q  <= cfg_data;
				default:      ; // writes beyond the register list are dropped
			endcase
		end
	end

	// ---------------------------------------------------------------- drive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q <= 1'b0;
			phase_q    <= 3'd0;
			tick_q     <= 10'd0;
			coil_q     <= 4'd0;
			motion_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (do_done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (do_done) begin
				run_mode_q <= run_q;
				if (!run_q) begin
					// centred: coils off, counter and flag cleared, phase kept
					tick_q   <= 10'd0;
					coil_q   <= 4'd0;
					motion_q <= 1'b0;
				end else if (step) begin
					tick_q   <= 10'd0;
					phase_q  <= phase_step;
					coil_q   <= coil_lookup(phase_step);
					motion_q <= neg_q;
				end else begin
					tick_q   <= tick_inc;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, run_mode_q, motion_q, coil_q};

	// ---------------------------------------------------------------- assertions
	// one tick at a time: a transfer in leaves the input closed
	`JSHS_ASSERT_NEXT(a_busy_after_take, in_take, !s_tready)
	// an idle result has the coils off and the flag clear
	`JSHS_ASSERT_NOW(a_idle_coils_off, m_tvalid && !m_tdata[5], m_tdata[3:0] == 4'd0 && !m_tdata[4])
	// the offset never exceeds the distance to mid-scale, so the quotient stays within span
	`JSHS_ASSERT_NOW(a_quot_in_span, state_q == ST_IV, prod_q <= PW'(span_q))
	// a result is produced only when the slot is free, never overwriting a pending one
	`JSHS_ASSERT_NOW(a_no_overwrite, do_done, !m_tvalid_q || m_tready)

endmodule

`default_nettype wire

>>> dv/tb_joystick_stepper_half_step_drive.sv
// ----------------------------------------------------------------------------
// tb_joystick_stepper_half_step_drive
// drives joystick ticks and register writes into the half-step drive, keeps
// its own copy of the sequencer state to predict every coil/flag/running
// result, and compares each output transfer against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module tb_joystick_stepper_half_step_drive;
	import jshs_pkg::*;

	localparam int          SAMPLE_BITS  = 10;
	localparam int          TDATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int unsigned MID_SCALE    = 1 << (SAMPLE_BITS - 1);
	localparam int unsigned FULL_SCALE   = (1 << SAMPLE_BITS) - 1;
	localparam int          MAX_CYCLES   = 1_000_000;
	localparam int          DRAIN_CYCLES = 40;
	localparam int          MAX_PRINTS   = 40;

	// half-step coil sequence, phase 0 in the lowest nibble
	localparam logic [31:0] HALF_STEP_SEQ = 32'h98C4_6231;

	// packed to match m_tdata: coils in the low nibble, then motion, running
	typedef struct packed {
		logic       running;
		logic       motion;
		logic [3:0] coils;
	} drive_out_t;

	// clock, reset and block inputs, all known from time zero
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               s_tvalid  = 1'b0;
	logic [TDATA_W-1:0] s_tdata   = '0;
	logic               m_tready  = 1'b0;
	logic               cfg_valid = 1'b0;
	logic [1:0]         cfg_index = REG_DEADBAND;
	logic [9:0]         cfg_data  = '0;

	logic               s_tready;
	logic               m_tvalid;
	logic [7:0]         m_tdata;
	logic               cfg_ready;

	// stimulus and scoreboard
	logic [TDATA_W-1:0] sample_q[$];          // ticks waiting for the driver
	drive_out_t         expected_drive_q[$];  // predicted results, oldest first
	int                 queued_items = 0;
	int                 idle_pct     = 13;
	bit                 sender_hold  = 1'b0;
	int                 mismatches   = 0;
	int                 cycle_count  = 0;

	// predictor copy of the registers
	logic [8:0] deadband_r = DEADBAND_RST;
	logic [9:0] slowest_r  = SLOWEST_RST;
	logic [9:0] fastest_r  = FASTEST_RST;

	// predictor copy of the sequencer state
	logic       running_r = 1'b0;
	logic [2:0] phase_r   = '0;
	logic [9:0] ticks_r   = '0;
	logic [3:0] coils_r   = '0;
	logic       motion_r  = 1'b0;

	joystick_stepper_half_step_drive #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // joystick_sample
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // coil_pattern[3:0], motion_flag, running
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// one joystick tick through the sequencer: updates the predictor state and
	// returns the result the block should hand out for it
	function automatic drive_out_t step_drive(input logic [TDATA_W-1:0] raw);
		int unsigned smp, mag, span, den, dec, interval;
		bit          fwd;
		smp = 32'(raw[SAMPLE_BITS-1:0]);    // bits above the sample width are don't-care
		fwd = smp < MID_SCALE;              // below mid-scale steps forward
		mag = fwd ? MID_SCALE - smp : smp - MID_SCALE;
		if (mag > deadband_r) begin
			// interval falls linearly from slowest to fastest, clamped at fastest
			span = (slowest_r > fastest_r) ? slowest_r - fastest_r : 0;
			den  = MID_SCALE - deadband_r;
			if (den == 0)
				den = 1;
			dec      = ((mag - deadband_r) * span) / den;
			interval = (dec <= slowest_r) ? slowest_r - dec : 0;
			if (interval < fastest_r)
				interval = fastest_r;
			running_r = 1'b1;
			ticks_r   = ticks_r + 10'd1;
			if (ticks_r >= interval) begin
				ticks_r = '0;
				if (fwd) begin
					phase_r  = phase_r + 3'd1;
					motion_r = 1'b1;
				end else begin
					phase_r  = phase_r - 3'd1;
					motion_r = 1'b0;
				end
				coils_r = HALF_STEP_SEQ[phase_r*4 +: 4];
			end
		end else begin
			// centred: coils off, counter and flag cleared, phase kept
			running_r = 1'b0;
			coils_r   = '0;
			motion_r  = 1'b0;
			ticks_r   = '0;
		end
		return '{coils: coils_r, motion: motion_r, running: running_r};
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// clamps to the sample range; a quarter of the ticks carry junk above it
	function automatic void push_sample(input int s);
		logic [TDATA_W-1:0] raw;
		if (s < 0)
			s = 0;
		if (s > int'(FULL_SCALE))
			s = int'(FULL_SCALE);
		raw = TDATA_W'(s);
		if ($urandom_range(3) == 0)
			raw[TDATA_W-1:SAMPLE_BITS] = (TDATA_W - SAMPLE_BITS)'($urandom);
		sample_q.push_back(raw);
		queued_items++;
	endfunction

	// joystick gestures: mostly held deflections with jitter, so the counter
	// actually reaches the interval, plus deadband edges, centring and noise
	task automatic queue_gestures(input int n, input int db);
		int target, kind, len, depth, level;
		target = queued_items + n;
		while (queued_items < target) begin
			kind = $urandom_range(9);
			if (kind <= 5) begin
				depth = $urandom_range(0, MID_SCALE);
				level = $urandom_range(1) ? MID_SCALE + depth : MID_SCALE - depth;
				len   = $urandom_range(1, 40);
				repeat (len)
					push_sample(level + int'($urandom_range(0, 6)) - 3);
			end else if (kind == 6) begin
				// both sides of both deadband edges
				push_sample(MID_SCALE - db);
				push_sample(MID_SCALE - db - 1);
				push_sample(MID_SCALE + db);
				push_sample(MID_SCALE + db + 1);
			end else if (kind == 7) begin
				len = $urandom_range(1, 10);
				repeat (len)
					push_sample(MID_SCALE - db + int'($urandom_range(0, 2 * db)));
			end else begin
				len = $urandom_range(1, 8);
				repeat (len)
					push_sample($urandom_range(0, FULL_SCALE));
			end
		end
	endtask

	// checked at the falling edge so every transfer of the rising edge is settled
	task automatic wait_drained();
		while (sample_q.size() != 0 || s_tvalid || expected_drive_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[9:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// one settings phase: drain, retune all three registers, then gestures;
	// with hold set the sender stops halfway until every result is back
	task automatic run_phase(input int db, input int slow, input int fast,
			input int n, input int idle, input bit hold);
		wait_drained();
		repeat (4) @(posedge clk);
		write_reg(REG_DEADBAND, db);
		write_reg(REG_SLOWEST, slow);
		write_reg(REG_FASTEST, fast);
		idle_pct = idle;
		queue_gestures(n, db);
		if (hold) begin
			while (sample_q.size() > n / 2)
				@(negedge clk);
			sender_hold = 1'b1;
			while (s_tvalid || expected_drive_q.size() != 0)
				@(negedge clk);
			sender_hold = 1'b0;
		end
	endtask

	// sender: holds a tick until its transfer, then may idle before the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (sample_q.size() != 0 && !sender_hold && $urandom_range(99) >= idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= sample_q.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure on the result stream
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= idle_pct);
	end

	// monitor: mirrors register writes, predicts on input transfers and
	// checks output transfers field by field
	always @(posedge clk) begin : monitor
		drive_out_t want;
		drive_out_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEADBAND: deadband_r = cfg_data[8:0];
					REG_SLOWEST:  slowest_r  = cfg_data;
					REG_FASTEST:  fastest_r  = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_drive_q.push_back(step_drive(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata[5:0];
				if (expected_drive_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result %h", m_tdata));
				end else begin
					want = expected_drive_q.pop_front();
					if (got.coils !== want.coils)
						report_mismatch($sformatf("coil_pattern got %h want %h",
							got.coils, want.coils));
					if (got.motion !== want.motion)
						report_mismatch($sformatf("motion_flag got %b want %b",
							got.motion, want.motion));
					if (got.running !== want.running)
						report_mismatch($sformatf("running got %b want %b",
							got.running, want.running));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= MAX_CYCLES) begin
			$display("tb_joystick_stepper_half_step_drive failed");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset register values: full deflection both ways, centre,
		// deadband edges, a slow run with no step yet, junk above the sample
		push_sample(0);
		push_sample(0);
		push_sample(0);
		push_sample(0);
		push_sample(0);
		push_sample(FULL_SCALE);
		push_sample(FULL_SCALE);
		push_sample(FULL_SCALE);
		push_sample(FULL_SCALE);
		push_sample(FULL_SCALE);
		push_sample(MID_SCALE);                // idle, phase kept
		push_sample(0);                        // coils off until the first step
		push_sample(0);
		push_sample(0);
		push_sample(MID_SCALE - DEADBAND_RST);       // on the edge: idle
		push_sample(MID_SCALE - DEADBAND_RST - 1);   // just outside: slow run
		push_sample(MID_SCALE - DEADBAND_RST - 1);   // no step yet, coils held
		push_sample(MID_SCALE + DEADBAND_RST + 1);
		push_sample(MID_SCALE + DEADBAND_RST);
		sample_q.push_back({TDATA_W{1'b1}});
		sample_q.push_back({{(TDATA_W - SAMPLE_BITS){1'b1}}, {SAMPLE_BITS{1'b0}}});
		sample_q.push_back({{(TDATA_W - SAMPLE_BITS){1'b1}}, {SAMPLE_BITS{1'b0}}});
		push_sample(MID_SCALE);

		// no deadband and a zero interval at full throw: step every tick
		run_phase(0, 1, 0, 200, 13, 1'b0);
		// widest deadband and longest interval: only the bottom code runs
		run_phase(511, 1023, 1023, 120, 13, 1'b0);
		// fastest above slowest: interval pinned at the clamp
		run_phase(10, 5, 100, 200, 13, 1'b0);
		// sender pauses midway until every result has come back
		run_phase(200, 40, 3, 250, 13, 1'b1);
		// long stretch with no idling on either side
		run_phase(50, 8, 1, 300, 0, 1'b0);
		run_phase(100, 1023, 0, 250, 13, 1'b0);
		run_phase(300, 2, 2, 200, 13, 1'b0);
		run_phase(int'(DEADBAND_RST), int'(SLOWEST_RST), int'(FASTEST_RST), 300, 13, 1'b0);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_joystick_stepper_half_step_drive passed");
		else
			$display("tb_joystick_stepper_half_step_drive failed");
		$finish;
	end

endmodule

`default_nettype wire
